/* rtl/clcd4w_pkg.sv */
package clcd4w_pkg;

	// request kinds
	typedef enum logic [1:0] {
		KIND_CMD    = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_MOVE   = 2'd2,
		KIND_NUMBER = 2'd3
	} kind_t;

	// width of the number field on the request channel
	localparam int NUM_FIELD_W = 32;

	// one request transaction
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [2:0]  row;
		logic [5:0]  column;
		logic [31:0] number;
	} req_t;

	// one strobe transaction
	typedef struct packed {
		logic       reg_select;
		logic [3:0] nibble;
		logic [3:0] wait_us;
		logic       last;
	} strobe_t;

	// cursor move command bases per row
	localparam logic [7:0] ROW1_BASE = 8'h80;
	localparam logic [7:0] ROW2_BASE = 8'hC0;
	localparam logic [7:0] ROW3_BASE = 8'h94;
	localparam logic [7:0] ROW4_BASE = 8'hD4;

	// high nibble of an ascii digit
	localparam logic [3:0] DIGIT_HI = 4'h3;

	// waits after enable falls, in microseconds
	localparam logic [3:0] WAIT_SHORT = 4'd1;
	localparam logic [3:0] WAIT_DATA  = 4'd10;

	// top level sequencer states
	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_CONV,
		CTL_SEND
	} ctl_state_t;

	// decimal converter states
	typedef enum logic [1:0] {
		DEC_IDLE,
		DEC_SHIFT,
		DEC_TRIM,
		DEC_READY
	} dec_state_t;

	// sequencer to converter
	typedef struct packed {
		logic start;
		logic advance;
	} dec_ctrl_t;

	// converter to sequencer
	typedef struct packed {
		logic       ready;
		logic       final_digit;
		logic [3:0] digit;
	} dec_stat_t;

endpackage

/* rtl/clcd4w_dec.sv */
module clcd4w_dec #(
	parameter int NUMBER_WIDTH = 32,
	parameter int MAX_DIGITS   = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  clcd4w_pkg::dec_ctrl_t   ctrl,
	input  logic [NUMBER_WIDTH-1:0] value,
	output clcd4w_pkg::dec_stat_t   stat
);
	import clcd4w_pkg::*;

	localparam int BCD_W     = MAX_DIGITS * 4;
	localparam int BIT_CNT_W = $clog2(NUMBER_WIDTH + 1);
	localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

	dec_state_t             state_q, state_d;
	logic [NUMBER_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   ovf_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic [3:0]             top_digit;
	logic                   final_digit;
	logic                   trim_more;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_digit   = bcd_q[BCD_W-1 -: 4];
	assign final_digit = (dig_cnt_q == DIG_CNT_W'(1));
	// drop leading zeros unless the value overflowed the digit window
	assign trim_more   = !ovf_q && (dig_cnt_q > DIG_CNT_W'(1)) && (top_digit == 4'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DEC_IDLE: begin
				if (ctrl.start) state_d = DEC_SHIFT;
			end
			DEC_SHIFT: begin
				if (bit_cnt_q == BIT_CNT_W'(1)) state_d = DEC_TRIM;
			end
			DEC_TRIM: begin
				if (!trim_more) state_d = DEC_READY;
			end
			DEC_READY: begin
				if (ctrl.advance && final_digit) state_d = DEC_IDLE;
			end
			default: state_d = DEC_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.ready       = (state_q == DEC_READY);
		stat.final_digit = final_digit;
		stat.digit       = top_digit;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= DEC_IDLE;
			ovf_q     <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				DEC_IDLE: begin
					if (ctrl.start) begin
						ovf_q     <= 1'b0;
						bit_cnt_q <= BIT_CNT_W'(NUMBER_WIDTH);
					end
				end
				DEC_SHIFT: begin
					ovf_q     <= ovf_q | bcd_adj[BCD_W-1];
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					dig_cnt_q <= DIG_CNT_W'(MAX_DIGITS);
				end
				DEC_TRIM: begin
					if (trim_more) dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
				end
				DEC_READY: begin
					if (ctrl.advance && !final_digit) dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// binary and bcd shift registers, one bit per cycle, then one digit per step
	always_ff @(posedge clk) begin
		case (state_q)
			DEC_IDLE: begin
				if (ctrl.start) begin
					bin_q <= value;
					bcd_q <= '0;
				end
			end
			DEC_SHIFT: begin
				bin_q <= {bin_q[NUMBER_WIDTH-2:0], 1'b0};
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUMBER_WIDTH-1]};
			end
			DEC_TRIM: begin
				if (trim_more) bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			DEC_READY: begin
				if (ctrl.advance) bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			default: ;
		endcase
	end

endmodule

/* rtl/char_lcd_four_bit_writer.sv */
// sequence: a command, data or in-range move request is registered, then sends its first
// strobe through the output register; a number first runs bit-serial double dabble, drops
// leading zeros (up to MAX_DIGITS - 1) and hands its digits off to the sequencer
// throughput: one strobe per cycle while sending and unstalled; a new request is not taken
// until the last strobe of the one before is in the output register; a bad row sends nothing
// reset: asynchronous active low, returns to idle with no strobe pending
module char_lcd_four_bit_writer #(
	parameter int NUMBER_WIDTH = 32,
	parameter int MAX_DIGITS   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  clcd4w_pkg::req_t    req_data,
	output logic                strb_valid,
	input  logic                strb_stall,
	output clcd4w_pkg::strobe_t strb_data
);
	import clcd4w_pkg::*;

	ctl_state_t              state_q, state_d;
	logic [7:0]              byte_q;
	logic                    rs_q;
	logic                    num_q;
	logic                    half_q;
	strobe_t                 out_q;
	logic                    out_valid_q;
	logic                    accept;
	logic                    row_ok;
	logic [7:0]              row_base;
	logic [7:0]              move_cmd;
	logic [7:0]              cur_byte;
	logic                    slot_free;
	logic                    send;
	strobe_t                 next_strobe;
	logic [NUMBER_WIDTH-1:0] num_value;
	dec_ctrl_t               dec_ctrl;
	dec_stat_t               dec_stat;

	// bring the number field to the conversion width
	generate
		if (NUMBER_WIDTH <= NUM_FIELD_W) begin : g_num_trunc
			assign num_value = req_data.number[NUMBER_WIDTH-1:0];
		end else begin : g_num_ext
			assign num_value = {{(NUMBER_WIDTH-NUM_FIELD_W){1'b0}}, req_data.number};
		end
	endgenerate

	// row base lookup for a cursor move
	always_comb begin
		row_ok   = 1'b1;
		row_base = ROW1_BASE;
		case (req_data.row)
			3'd1: row_base = ROW1_BASE;
			3'd2: row_base = ROW2_BASE;
			3'd3: row_base = ROW3_BASE;
			3'd4: row_base = ROW4_BASE;
			default: row_ok = 1'b0;
		endcase
	end

	assign move_cmd  = row_base + {2'b00, req_data.column} - 8'd1;
	assign req_stall = (state_q != CTL_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !out_valid_q || !strb_stall;

	// assemble the next strobe
	assign cur_byte = num_q ? {DIGIT_HI, dec_stat.digit} : byte_q;
	always_comb begin
		next_strobe.reg_select = rs_q;
		next_strobe.nibble     = half_q ? cur_byte[3:0] : cur_byte[7:4];
		next_strobe.wait_us    = (rs_q && half_q) ? WAIT_DATA : WAIT_SHORT;
		next_strobe.last       = half_q && (!num_q || dec_stat.final_digit);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (accept) begin
					case (req_data.kind)
						KIND_CMD, KIND_DATA: state_d = CTL_SEND;
						KIND_MOVE: state_d = row_ok ? CTL_SEND : CTL_IDLE;
						KIND_NUMBER: state_d = CTL_CONV;
						default: state_d = CTL_IDLE;
					endcase
				end
			end
			CTL_CONV: begin
				if (dec_stat.ready) state_d = CTL_SEND;
			end
			CTL_SEND: begin
				if (slot_free && next_strobe.last) state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		send             = 1'b0;
		dec_ctrl.start   = 1'b0;
		dec_ctrl.advance = 1'b0;
		case (state_q)
			CTL_IDLE: begin
				dec_ctrl.start = accept && (req_data.kind == KIND_NUMBER);
			end
			CTL_SEND: begin
				send             = slot_free;
				dec_ctrl.advance = slot_free && half_q && num_q;
			end
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
			half_q  <= 1'b0;
			num_q   <= 1'b0;
			rs_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				half_q <= 1'b0;
				num_q  <= (req_data.kind == KIND_NUMBER);
				rs_q   <= (req_data.kind == KIND_DATA) || (req_data.kind == KIND_NUMBER);
			end else if (send) begin
				half_q <= !half_q;
			end
		end
	end

	// byte to send for command, data and move requests
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= (req_data.kind == KIND_MOVE) ? move_cmd : req_data.byte_value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= send;
		end
	end

	always_ff @(posedge clk) begin
		if (send) out_q <= next_strobe;
	end

	assign strb_valid = out_valid_q;
	assign strb_data  = out_q;

	// decimal converter
	clcd4w_dec #(
		.NUMBER_WIDTH(NUMBER_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dec (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (dec_ctrl),
		.value (num_value),
		.stat  (dec_stat)
	);

endmodule

/* test/tb_char_lcd_four_bit_writer.sv */
module tb_char_lcd_four_bit_writer;
	import clcd4w_pkg::*;

	localparam int DIGITS_MAX   = 10;
	localparam int RANDOM_ITEMS = 350;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 120;

	// strobe scoreboard: predicts the nibble strobes of each request
	class lcd_strobe_scoreboard;
		strobe_t expected_strobes[$];
		int      mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return expected_strobes.size();
		endfunction

		// one byte is two strobes, high nibble first
		function void push_byte(ref strobe_t burst[$], input logic rs, input logic [7:0] b);
			strobe_t s;
			s.reg_select = rs;
			s.last       = 1'b0;
			s.nibble     = b[7:4];
			s.wait_us    = WAIT_SHORT;
			burst.push_back(s);
			s.nibble     = b[3:0];
			s.wait_us    = rs ? WAIT_DATA : WAIT_SHORT;
			burst.push_back(s);
		endfunction

		function void note_request(req_t r);
			strobe_t     burst[$];
			strobe_t     s;
			logic [7:0]  base;
			logic [31:0] v;
			logic [3:0]  digits[DIGITS_MAX];
			int          cnt;
			base = 8'h00;
			case (r.kind)
				KIND_CMD:  push_byte(burst, 1'b0, r.byte_value);
				KIND_DATA: push_byte(burst, 1'b1, r.byte_value);
				KIND_MOVE: begin
					case (r.row)
						3'd1: base = ROW1_BASE;
						3'd2: base = ROW2_BASE;
						3'd3: base = ROW3_BASE;
						3'd4: base = ROW4_BASE;
						default: base = 8'h00;
					endcase
					// rows outside 1..4 produce nothing
					if (r.row >= 3'd1 && r.row <= 3'd4)
						push_byte(burst, 1'b0, base + ({2'b00, r.column} - 8'd1));
				end
				default: begin
					// decimal digits, least significant first, then sent in reverse
					v   = r.number;
					cnt = 0;
					do begin
						digits[cnt] = 4'(v % 10);
						v           = v / 10;
						cnt++;
					end while (v != 0 && cnt < DIGITS_MAX);
					for (int i = cnt - 1; i >= 0; i--)
						push_byte(burst, 1'b1, {DIGIT_HI, digits[i]});
				end
			endcase
			if (burst.size() > 0) begin
				s      = burst.pop_back();
				s.last = 1'b1;
				burst.push_back(s);
			end
			foreach (burst[i])
				expected_strobes.push_back(burst[i]);
		endfunction

		function void flag_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp, act);
				mismatches++;
			end
		endfunction

		function void check_strobe(strobe_t act);
			strobe_t exp;
			if (expected_strobes.size() == 0) begin
				$display("%0t unexpected strobe: expected none, got rs=%0d nib=%h wait=%0d last=%0d",
					$time, act.reg_select, act.nibble, act.wait_us, act.last);
				mismatches++;
				return;
			end
			exp = expected_strobes.pop_front();
			flag_field("reg_select", exp.reg_select, act.reg_select);
			flag_field("nibble", exp.nibble, act.nibble);
			flag_field("wait_us", exp.wait_us, act.wait_us);
			flag_field("last", exp.last, act.last);
		endfunction
	endclass

	logic    clk        = 1'b0;
	logic    arst_n     = 1'b0;
	logic    req_valid  = 1'b0;
	logic    req_stall;
	req_t    req_data   = '0;
	logic    strb_valid;
	logic    strb_stall = 1'b0;
	strobe_t strb_data;

	lcd_strobe_scoreboard sb;
	bit steady     = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;

	char_lcd_four_bit_writer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.strb_valid (strb_valid),
		.strb_stall (strb_stall),
		.strb_data  (strb_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic req_t make_req(kind_t k, logic [7:0] bv, logic [2:0] row,
		logic [5:0] col, logic [31:0] num);
		req_t r;
		r.kind       = k;
		r.byte_value = bv;
		r.row        = row;
		r.column     = col;
		r.number     = num;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int   sel;
		r.kind       = kind_t'($urandom_range(0, 3));
		r.byte_value = 8'($urandom_range(0, 255));
		r.row        = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		r.column     = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(1, 40));
		sel = $urandom_range(0, 2);
		if (sel == 0)
			r.number = $urandom_range(0, 99);
		else if (sel == 1)
			r.number = $urandom_range(0, 999999);
		else
			r.number = $urandom;
		return r;
	endfunction

	// drive one request transaction and wait for it to be taken
	task automatic send_request(input req_t r);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// output side back-pressure
	always @(negedge clk) begin
		if (stall_left == 0)
			stall_left = steady ? 0 : pick_gap();
		if (stall_left > 0) begin
			strb_stall <= 1'b1;
			stall_left--;
		end else begin
			strb_stall <= 1'b0;
		end
	end

	// strobe monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (strb_valid && !strb_stall)
				sb.check_strobe(strb_data);
			if ((strb_valid && !strb_stall) || (req_valid && !req_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog expired with %0d strobes outstanding", $time, sb.pending());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		req_t directed[$];
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed requests: byte extremes, every row, odd columns, number edges
		directed.push_back(make_req(KIND_CMD, 8'h00, 3'd0, 6'd0, 32'd0));
		directed.push_back(make_req(KIND_CMD, 8'hFF, 3'd7, 6'd63, 32'hFFFF_FFFF));
		directed.push_back(make_req(KIND_DATA, 8'h00, 3'd0, 6'd0, 32'd0));
		directed.push_back(make_req(KIND_DATA, 8'hFF, 3'd7, 6'd63, 32'hFFFF_FFFF));
		directed.push_back(make_req(KIND_DATA, 8'h5A, 3'd2, 6'd5, 32'd12));
		directed.push_back(make_req(KIND_MOVE, 8'hFF, 3'd1, 6'd1, 32'hFFFF_FFFF));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd2, 6'd40, 32'd0));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd3, 6'd0, 32'd0));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd4, 6'd63, 32'd0));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd1, 6'd17, 32'd0));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd0, 6'd5, 32'd0));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd5, 6'd5, 32'd0));
		directed.push_back(make_req(KIND_MOVE, 8'h00, 3'd7, 6'd5, 32'd0));
		directed.push_back(make_req(KIND_NUMBER, 8'hFF, 3'd7, 6'd63, 32'd0));
		directed.push_back(make_req(KIND_NUMBER, 8'h00, 3'd0, 6'd0, 32'd7));
		directed.push_back(make_req(KIND_NUMBER, 8'h00, 3'd0, 6'd0, 32'd10));
		directed.push_back(make_req(KIND_NUMBER, 8'h00, 3'd0, 6'd0, 32'd99999));
		directed.push_back(make_req(KIND_NUMBER, 8'h00, 3'd0, 6'd0, 32'd1000000000));
		directed.push_back(make_req(KIND_NUMBER, 8'h00, 3'd0, 6'd0, 32'hFFFF_FFFF));
		directed.push_back(make_req(KIND_CMD, 8'h28, 3'd4, 6'd33, 32'h8000_0001));
		foreach (directed[i])
			send_request(directed[i]);

		// random requests, with a back-to-back stretch and one full drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 100 && n < 150);
			if (n == 200) begin
				@(negedge clk);
				req_valid <= 1'b0;
				wait_drained();
			end
			send_request(random_req());
		end
		steady = 1'b0;

		@(negedge clk);
		req_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/clcd4w_pkg.sv
rtl/clcd4w_dec.sv
rtl/char_lcd_four_bit_writer.sv
test/tb_char_lcd_four_bit_writer.sv
